// ===== sv/plt_pkg.sv =====
package plt_pkg;

    localparam int PLT_CAPACITY = 16;

    localparam int PLT_OP_W    = 2;
    localparam int PLT_VALUE_W = 32;
    localparam int PLT_POS_W   = 5;
    localparam int PLT_IN_W    = 40;
    localparam int PLT_OUT_W   = 48;

    typedef enum logic [PLT_OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic load_hits;
        logic scan_step;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_search;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/plt_ctrl.sv =====
module plt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  plt_pkg::t_sts  i_sts,
    output plt_pkg::t_cmd  o_cmd
);
    import plt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_search) begin
                    o_cmd.load_hits = 1'b1;
                    n_state         = S_SCAN;
                end else if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!i_sts.scan_done) begin
                    o_cmd.scan_step = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/plt_datapath.sv =====
module plt_datapath #(
    parameter int CAPACITY = plt_pkg::PLT_CAPACITY
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  plt_pkg::t_cmd                   i_cmd,
    output plt_pkg::t_sts                   o_sts,
    input  logic [plt_pkg::PLT_OP_W-1:0]    i_opcode,
    input  logic [plt_pkg::PLT_VALUE_W-1:0] i_data_value,
    input  logic [plt_pkg::PLT_POS_W-1:0]   i_position,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_ok,
    output logic [plt_pkg::PLT_VALUE_W-1:0] o_value_out,
    output logic [plt_pkg::PLT_POS_W-1:0]   o_found_position,
    output logic [plt_pkg::PLT_POS_W-1:0]   o_list_length
);
    import plt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > PLT_POS_W) ? CW : PLT_POS_W;
    // a 5-bit position reaches at most entry 31
    localparam int RD = (CAPACITY < 32) ? CAPACITY : 32;

    logic [PLT_VALUE_W-1:0] r_cells [CAPACITY];
    logic [PLT_VALUE_W-1:0] n_cells [CAPACITY];
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;

    t_op                    r_op;
    logic [PLT_VALUE_W-1:0] r_val;
    logic [PLT_POS_W-1:0]   r_pos;

    logic [CAPACITY-1:0]    r_hits;
    logic [CW-1:0]          r_scan_idx;

    logic                   r_out_valid;
    logic                   r_ok;
    logic [PLT_VALUE_W-1:0] r_value_out;
    logic [PLT_POS_W-1:0]   r_found_position;
    logic [PLT_POS_W-1:0]   r_list_length;

    logic                   n_ok;
    logic [PLT_VALUE_W-1:0] n_value_out;
    logic [PLT_POS_W-1:0]   n_found_position;

    logic [PW-1:0]          pos_ext;
    logic [PW-1:0]          cnt_ext;
    logic                   in_range;
    logic                   ins_ok;
    logic [PLT_POS_W-1:0]   rd_idx;
    logic [PLT_VALUE_W-1:0] rd_val;
    logic                   out_free;
    logic                   scan_done;

    assign pos_ext   = PW'(r_pos);
    assign cnt_ext   = PW'(r_count);
    assign in_range  = (r_pos != '0) && (pos_ext <= cnt_ext);
    assign ins_ok    = (pos_ext <= cnt_ext) && (r_count < CW'(CAPACITY));
    assign rd_idx    = r_pos - PLT_POS_W'(1);
    assign out_free  = !r_out_valid || i_out_ready;
    assign scan_done = r_hits[0] || (r_scan_idx >= r_count);

    assign o_sts.is_search = (r_op == OP_SEARCH);
    assign o_sts.scan_done = scan_done;
    assign o_sts.out_free  = out_free;

    always_comb begin
        rd_val = '0;
        for (int i = 0; i < RD; i++) begin
            if (PLT_POS_W'(i) == rd_idx) begin
                rd_val = r_cells[i];
            end
        end
    end

    // shift the row back on insert, forward on remove
    always_comb begin
        n_cells = r_cells;
        n_count = r_count;
        if (i_cmd.commit && (r_op == OP_INSERT) && ins_ok) begin
            n_count = r_count + CW'(1);
            if (r_pos == '0) begin
                n_cells[0] = r_val;
            end
            for (int i = 1; i < CAPACITY; i++) begin
                if (PW'(i) == pos_ext) begin
                    n_cells[i] = r_val;
                end else if (PW'(i) > pos_ext) begin
                    n_cells[i] = r_cells[i-1];
                end
            end
        end
        if (i_cmd.commit && (r_op == OP_REMOVE) && in_range) begin
            n_count = r_count - CW'(1);
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (PW'(i + 1) >= pos_ext) begin
                    n_cells[i] = r_cells[i+1];
                end
            end
        end
    end

    always_comb begin
        n_ok             = 1'b0;
        n_value_out      = '0;
        n_found_position = '0;
        case (r_op)
            OP_INSERT: begin
                n_ok = ins_ok;
            end
            OP_REMOVE: begin
                n_ok = in_range;
                if (in_range) begin
                    n_value_out = rd_val;
                end
            end
            OP_READ: begin
                n_ok        = in_range;
                n_value_out = in_range ? rd_val : '1;
            end
            OP_SEARCH: begin
                n_ok = r_hits[0];
                if (r_hits[0]) begin
                    n_found_position = PLT_POS_W'(r_scan_idx + CW'(1));
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
        if (i_cmd.capture) begin
            r_val <= i_data_value;
            r_pos <= i_position;
        end
        if (i_cmd.load_hits) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_hits[i] <= (r_cells[i] == r_val) && (CW'(i) < r_count);
            end
        end else if (i_cmd.scan_step) begin
            r_hits <= r_hits >> 1;
        end
        if (i_cmd.commit) begin
            r_ok             <= n_ok;
            r_value_out      <= n_value_out;
            r_found_position <= n_found_position;
            r_list_length    <= PLT_POS_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_op        <= OP_INSERT;
            r_scan_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.capture) begin
                r_op <= t_op'(i_opcode);
            end
            if (i_cmd.load_hits) begin
                r_scan_idx <= '0;
            end else if (i_cmd.scan_step) begin
                r_scan_idx <= r_scan_idx + CW'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_ok             = r_ok;
    assign o_value_out      = r_value_out;
    assign o_found_position = r_found_position;
    assign o_list_length    = r_list_length;

endmodule

// ===== sv/positional_list_table.sv =====
// Ordered list of signed 32-bit entries, up to CAPACITY of them.
// Slave stream carries one request per beat; master stream returns one
// result beat per request, in order.
// Request opcodes: insert after a position (0 = front), remove at a 1-based
// position, read at a 1-based position, search for the first equal value.
// Each result gives ok, the removed or read value (-1 on a failed read),
// the match position of a search and the list length after the request.
// From accept to result, insert, remove and read pass through the EXEC
// state; a search moves on from EXEC to SCAN, where the hit vector is
// scanned one entry a cycle up to the first match or the list length.
// The single execution unit handles one request at a time, and a result
// is committed only once the result register is free.
// One result register sits on the master side: a new request is accepted
// while the previous result waits, and it is held until that result is
// taken. A stalled master simply holds o_m_axis_tvalid and the data.
// Reset empties the list and drops any pending result.
module positional_list_table #(
    parameter int CAPACITY = plt_pkg::PLT_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // opcode[1:0], data_value[33:2], position[38:34], zero[39]
    input  logic [plt_pkg::PLT_IN_W-1:0]  i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // ok[0], value_out[32:1], found_position[37:33], list_length[42:38],
    // zero[47:43]
    output logic [plt_pkg::PLT_OUT_W-1:0] o_m_axis_tdata
);
    import plt_pkg::*;

    t_cmd                   cmd;
    t_sts                   sts;
    logic                   ok;
    logic [PLT_VALUE_W-1:0] value_out;
    logic [PLT_POS_W-1:0]   found_position;
    logic [PLT_POS_W-1:0]   list_length;

    plt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    plt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_opcode         (i_s_axis_tdata[1:0]),
        .i_data_value     (i_s_axis_tdata[33:2]),
        .i_position       (i_s_axis_tdata[38:34]),
        .o_out_valid      (o_m_axis_tvalid),
        .i_out_ready      (i_m_axis_tready),
        .o_ok             (ok),
        .o_value_out      (value_out),
        .o_found_position (found_position),
        .o_list_length    (list_length)
    );

    assign o_m_axis_tdata = {5'd0, list_length, found_position, value_out, ok};

    a_capture_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |-> (i_s_axis_tvalid && o_s_axis_tready))
        else $error("request captured without an input beat");

    a_commit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> sts.out_free)
        else $error("result committed while output register is occupied");

    a_commit_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_m_axis_tvalid)
        else $error("committed result not presented");

    a_no_step_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_step |-> !sts.scan_done)
        else $error("search scan advanced past its end");

endmodule

// ===== dv/plt_list_checker.sv =====
module plt_list_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    // opcode[1:0], data_value[33:2], position[38:34], zero[39]
    input  logic [plt_pkg::PLT_IN_W-1:0]  i_req_data,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    // ok[0], value_out[32:1], found_position[37:33], list_length[42:38],
    // zero[47:43]
    input  logic [plt_pkg::PLT_OUT_W-1:0] i_res_data,
    output int                            o_failures,
    output int                            o_pending
);
    import plt_pkg::*;

    typedef struct packed {
        logic                          ok;
        logic signed [PLT_VALUE_W-1:0] value_out;
        logic [PLT_POS_W-1:0]          found_position;
        logic [PLT_POS_W-1:0]          list_length;
    } t_list_result;

    logic [PLT_VALUE_W-1:0] list_entries [PLT_CAPACITY];
    int                     list_len;
    t_list_result           expected_results [$];

    function automatic t_list_result apply_list_op(t_op op, logic [PLT_VALUE_W-1:0] value,
                                                   logic [PLT_POS_W-1:0] pos);
        t_list_result r;
        int           p;
        int           idx;
        r = '0;
        p = pos;
        case (op)
            OP_INSERT: begin
                if (p <= list_len && list_len < PLT_CAPACITY) begin
                    for (idx = list_len; idx > p; idx--)
                        list_entries[idx] = list_entries[idx - 1];
                    list_entries[p] = value;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (p >= 1 && p <= list_len) begin
                    r.value_out = list_entries[p - 1];
                    // close the gap
                    for (idx = p - 1; idx + 1 < list_len; idx++)
                        list_entries[idx] = list_entries[idx + 1];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            OP_READ: begin
                if (p >= 1 && p <= list_len) begin
                    r.value_out = list_entries[p - 1];
                    r.ok = 1'b1;
                end else begin
                    r.value_out = '1;
                end
            end
            OP_SEARCH: begin
                for (idx = 0; idx < list_len; idx++) begin
                    if (list_entries[idx] == value) begin
                        r.found_position = PLT_POS_W'(idx + 1);
                        r.ok = 1'b1;
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.list_length = PLT_POS_W'(list_len);
        return r;
    endfunction

    task automatic check_result(t_list_result got);
        t_list_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: result beat with nothing expected: ok %0b value %0d pos %0d len %0d",
                     $time, got.ok, $signed(got.value_out), got.found_position,
                     got.list_length);
            o_failures++;
        end else begin
            want = expected_results.pop_front();
            if (got.ok !== want.ok) begin
                $display("%0t: ok expected %0b, got %0b", $time, want.ok, got.ok);
                o_failures++;
            end
            if (got.value_out !== want.value_out) begin
                $display("%0t: value_out expected %0d, got %0d", $time,
                         $signed(want.value_out), $signed(got.value_out));
                o_failures++;
            end
            if (got.found_position !== want.found_position) begin
                $display("%0t: found_position expected %0d, got %0d", $time,
                         want.found_position, got.found_position);
                o_failures++;
            end
            if (got.list_length !== want.list_length) begin
                $display("%0t: list_length expected %0d, got %0d", $time,
                         want.list_length, got.list_length);
                o_failures++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            expected_results.delete();
            o_failures = 0;
        end else begin
            if (i_req_valid && i_req_ready)
                expected_results.push_back(apply_list_op(t_op'(i_req_data[1:0]),
                                                         i_req_data[33:2],
                                                         i_req_data[38:34]));
            if (i_res_valid && i_res_ready)
                check_result('{ok: i_res_data[0], value_out: i_res_data[32:1],
                               found_position: i_res_data[37:33],
                               list_length: i_res_data[42:38]});
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== dv/positional_list_table_test.sv =====
module positional_list_table_test;
    import plt_pkg::*;

    localparam int RANDOM_REQUESTS = 1420;
    localparam int CALM_TAIL       = 150;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    // opcode[1:0], data_value[33:2], position[38:34], zero[39]
    logic [PLT_IN_W-1:0]  i_s_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    // ok[0], value_out[32:1], found_position[37:33], list_length[42:38],
    // zero[47:43]
    logic [PLT_OUT_W-1:0] o_m_axis_tdata;

    int fail_count;
    int pending_count;
    int shadow_len;
    bit calm;

    positional_list_table i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    plt_list_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_req_ready (o_s_axis_tready),
        .i_req_data  (i_s_axis_tdata),
        .i_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .i_res_data  (o_m_axis_tdata),
        .o_failures  (fail_count),
        .o_pending   (pending_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("positional_list_table_test: errors");
        $finish;
    end

    // receiver: stall in bursts, sometimes stay ready for a long stretch
    initial begin
        int n;
        i_m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (!calm) begin
                n = $urandom_range(0, 19);
                if (n == 0) begin
                    i_m_axis_tready <= 1'b1;
                    repeat ($urandom_range(50, 200)) @(negedge i_clk);
                end else if (n < 3) begin
                    i_m_axis_tready <= 1'b0;
                    repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
                end else begin
                    i_m_axis_tready <= 1'b1;
                end
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_request(t_op op, logic [PLT_VALUE_W-1:0] value,
                                logic [PLT_POS_W-1:0] pos);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, pos, value, op};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        // track only the length, to steer positions into range
        if (op == OP_INSERT && pos <= shadow_len && shadow_len < PLT_CAPACITY)
            shadow_len++;
        else if (op == OP_REMOVE && pos >= 1 && pos <= shadow_len)
            shadow_len--;
    endtask

    task automatic hold_sender(int cycles);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= PLT_IN_W'({$urandom, $urandom});
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    function automatic logic [PLT_VALUE_W-1:0] pick_value();
        logic [PLT_VALUE_W-1:0] pool [8];
        pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0000_002A};
        if ($urandom_range(0, 9) < 6)
            return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [PLT_POS_W-1:0] pick_position(t_op op);
        if ($urandom_range(0, 99) < 15 || op == OP_SEARCH)
            return PLT_POS_W'($urandom_range(0, PLT_CAPACITY));
        if (op == OP_INSERT)
            return PLT_POS_W'($urandom_range(0, shadow_len));
        if (shadow_len == 0)
            return '0;
        return PLT_POS_W'($urandom_range(1, shadow_len));
    endfunction

    function automatic t_op pick_op(int bias);
        int r;
        r = $urandom_range(0, 99);
        case (bias)
            0: return r < 60 ? OP_INSERT : r < 70 ? OP_REMOVE : r < 85 ? OP_READ : OP_SEARCH;
            1: return r < 10 ? OP_INSERT : r < 70 ? OP_REMOVE : r < 85 ? OP_READ : OP_SEARCH;
            default: return t_op'(r % 4);
        endcase
    endfunction

    initial begin
        int   k;
        int   seg_left;
        int   bias;
        bit   steady;
        t_op  op;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        calm            = 1'b0;
        shadow_len      = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list: every access misses
        send_request(OP_READ,   32'd0, 5'd1);
        send_request(OP_REMOVE, 32'd0, 5'd0);
        send_request(OP_SEARCH, 32'd0, 5'd0);
        send_request(OP_INSERT, 32'd5, 5'd1);
        // build [-1, min, max]
        send_request(OP_INSERT, 32'h8000_0000, 5'd0);
        send_request(OP_INSERT, 32'h7FFF_FFFF, 5'd1);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 5'd0);
        send_request(OP_READ,   32'd0, 5'd0);
        send_request(OP_READ,   32'd0, 5'd3);
        send_request(OP_READ,   32'd0, 5'd4);
        send_request(OP_SEARCH, 32'h7FFF_FFFF, 5'd0);
        send_request(OP_REMOVE, 32'd0, 5'd4);
        send_request(OP_REMOVE, 32'd0, 5'd2);
        // fill to capacity, appending at the tail
        for (k = 0; shadow_len < PLT_CAPACITY; k++)
            send_request(OP_INSERT, 32'(1000 + k), PLT_POS_W'(shadow_len));
        send_request(OP_INSERT, 32'd7, 5'd0);
        send_request(OP_SEARCH, 32'(999 + k), 5'd0);
        send_request(OP_READ,   32'd0, 5'd16);
        send_request(OP_REMOVE, 32'd0, 5'd16);
        wait_drained();

        seg_left = 0;
        bias     = 2;
        steady   = 1'b0;
        for (k = 0; k < RANDOM_REQUESTS; k++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 80);
                bias     = $urandom_range(0, 2);
                steady   = ($urandom_range(0, 3) == 0);
            end
            seg_left--;
            if (k == RANDOM_REQUESTS / 2)
                wait_drained();
            calm = (k >= RANDOM_REQUESTS - CALM_TAIL);
            if (!calm && !steady && $urandom_range(0, 5) == 0)
                hold_sender($urandom_range(1, 18));
            op = pick_op(bias);
            send_request(op, pick_value(), pick_position(op));
        end

        wait_drained();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("positional_list_table_test: clean");
        else
            $display("positional_list_table_test: errors");
        $finish;
    end

endmodule
